FILE: rtl/zpm_pkg.sv
// zpm_pkg: shared widths, defaults, status codes and the controller/datapath
// command and status structs of the zoned page map translation unit.
// No dependencies.
`default_nettype none

package zpm_pkg;

   // default sizing of the block
   localparam int DEF_LOGICAL_BLOCKS = 65536;
   localparam int DEF_NUM_ZONES      = 64;
   localparam int DEF_MAX_RUN        = 64;

   // fixed field widths
   localparam int LB_W   = 16;
   localparam int CNT_W  = 7;
   localparam int ZB_W   = 17;
   localparam int WP_W   = 17;
   localparam int PHYS_W = 22;
   localparam int MOD_W  = LB_W + 1;

   // largest usable zone size
   localparam logic [ZB_W-1:0] ZB_MAX = 17'd65536;

   // result status codes
   typedef enum logic [1:0] {
      RS_OK       = 2'd0,
      RS_NO_ZONE  = 2'd1,
      RS_EMPTY    = 2'd2,
      RS_TOO_LONG = 2'd3
   } status_type;

   // controller states
   typedef enum logic [8:0] {
      S_CLEAR = 9'b000000001,
      S_IDLE  = 9'b000000010,
      S_MOD   = 9'b000000100,
      S_CHECK = 9'b000001000,
      S_MUL   = 9'b000010000,
      S_ADD   = 9'b000100000,
      S_WRITE = 9'b001000000,
      S_READ  = 9'b010000000,
      S_LAST  = 9'b100000000
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic       clear_wr;
      logic       accept;
      logic       mod_step;
      logic       pop;
      logic       close_zone;
      logic       mul;
      logic       add;
      logic       map_wr;
      logic       map_rd;
      logic       wp_advance;
      logic       emit;
      logic       emit_base;
      status_type emit_status;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic clear_done;
      logic mod_done;
      logic empty_req;
      logic too_long;
      logic is_write;
      logic fits;
      logic pool_empty;
      logic run_done;
   } stat_type;

endpackage

`default_nettype wire

FILE: rtl/zoned_page_map_ftl_unit.sv
// zoned_page_map_ftl_unit: top level of the zoned page map translation unit.
// Depends on zpm_pkg, zpm_ctrl and zpm_datapath.
//
//   channel   ports                                        handshake
//   request   req_func, req_logical_block, req_block_count start & !busy
//   response  rsp_physical_block, rsp_last, rsp_status     rsp_strobe, one cycle
//   csr       csr_data (zone_blocks)                       csr_valid & csr_ready
//
// A read passes S_MOD, S_CHECK and S_READ with one response per block; a write
// passes S_MOD, S_CHECK, S_MUL, S_ADD, S_WRITE and S_LAST with one response;
// failed requests respond from S_CHECK. The map table walk makes one memory
// port access per block; tables smaller than 65536 entries add the start index
// reduction steps. A clearing pass after reset zeroes all LOGICAL_BLOCKS map
// entries, one a cycle, with busy high; csr writes are taken throughout.
// Responses cannot be stalled: each one is shown for exactly one cycle.
`default_nettype none

module zoned_page_map_ftl_unit #(
   parameter int LOGICAL_BLOCKS = zpm_pkg::DEF_LOGICAL_BLOCKS,
   parameter int NUM_ZONES      = zpm_pkg::DEF_NUM_ZONES,
   parameter int MAX_RUN        = zpm_pkg::DEF_MAX_RUN
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic                        req_func,
   input  wire logic [zpm_pkg::LB_W-1:0]    req_logical_block,
   input  wire logic [zpm_pkg::CNT_W-1:0]   req_block_count,
   output logic                             rsp_strobe,
   output logic [zpm_pkg::PHYS_W-1:0]       rsp_physical_block,
   output logic                             rsp_last,
   output logic [1:0]                       rsp_status,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [zpm_pkg::ZB_W-1:0]    csr_data
);
   import zpm_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencer
   zpm_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // allocation, arithmetic and map table
   zpm_datapath #(
      .LOGICAL_BLOCKS (LOGICAL_BLOCKS),
      .NUM_ZONES      (NUM_ZONES),
      .MAX_RUN        (MAX_RUN)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_func           (req_func),
      .req_logical_block  (req_logical_block),
      .req_block_count    (req_block_count),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_data           (csr_data),
      .cmd                (cmd),
      .stat               (stat),
      .rsp_strobe         (rsp_strobe),
      .rsp_physical_block (rsp_physical_block),
      .rsp_last           (rsp_last),
      .rsp_status         (rsp_status)
   );

endmodule

`default_nettype wire

FILE: rtl/zpm_ctrl.sv
// zpm_ctrl: sequencing state machine of the zoned page map unit.
// Depends on zpm_pkg for the state, command and status types.
`default_nettype none

module zpm_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire zpm_pkg::stat_type stat,
   output zpm_pkg::cmd_type       cmd
);
   import zpm_pkg::*;

   state_type state_ff, state_in;

   // next state and command decode
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (stat.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = S_MOD;
            end
         end
         S_MOD: begin
            cmd.mod_step = 1'b1;
            if (stat.mod_done) state_in = S_CHECK;
         end
         S_CHECK: begin
            if (stat.empty_req) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = RS_EMPTY;
               state_in        = S_IDLE;
            end else if (stat.too_long) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = RS_TOO_LONG;
               state_in        = S_IDLE;
            end else if (!stat.is_write) begin
               state_in = S_READ;
            end else if (stat.fits) begin
               state_in = S_MUL;
            end else if (stat.pool_empty) begin
               cmd.close_zone  = 1'b1;
               cmd.emit        = 1'b1;
               cmd.emit_status = RS_NO_ZONE;
               state_in        = S_IDLE;
            end else begin
               cmd.pop  = 1'b1;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_ADD;
         end
         S_ADD: begin
            cmd.add  = 1'b1;
            state_in = S_WRITE;
         end
         S_WRITE: begin
            cmd.map_wr = 1'b1;
            if (stat.run_done) state_in = S_LAST;
         end
         S_LAST: begin
            // single write result once the run is mapped
            cmd.wp_advance  = 1'b1;
            cmd.emit        = 1'b1;
            cmd.emit_base   = 1'b1;
            cmd.emit_status = RS_OK;
            state_in        = S_IDLE;
         end
         S_READ: begin
            cmd.map_rd = 1'b1;
            if (stat.run_done) state_in = S_IDLE;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

`default_nettype wire

FILE: rtl/zpm_datapath.sv
// zpm_datapath: zone allocation registers, start index reduction, base address
// arithmetic, map table memory and result registers of the zoned page map unit.
// Depends on zpm_pkg.
`default_nettype none

module zpm_datapath #(
   parameter int LOGICAL_BLOCKS = zpm_pkg::DEF_LOGICAL_BLOCKS,
   parameter int NUM_ZONES      = zpm_pkg::DEF_NUM_ZONES,
   parameter int MAX_RUN        = zpm_pkg::DEF_MAX_RUN
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_func,
   input  wire logic [zpm_pkg::LB_W-1:0]    req_logical_block,
   input  wire logic [zpm_pkg::CNT_W-1:0]   req_block_count,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [zpm_pkg::ZB_W-1:0]    csr_data,
   input  wire zpm_pkg::cmd_type            cmd,
   output zpm_pkg::stat_type                stat,
   output logic                             rsp_strobe,
   output logic [zpm_pkg::PHYS_W-1:0]       rsp_physical_block,
   output logic                             rsp_last,
   output logic [1:0]                       rsp_status
);
   import zpm_pkg::*;

   localparam int AW     = $clog2(LOGICAL_BLOCKS);
   localparam int ZID_W  = $clog2(NUM_ZONES);
   localparam int MUL_W  = ZID_W + ZB_W;
   localparam bit NEED_MOD = (LOGICAL_BLOCKS < (1 << LB_W));
   localparam int MOD_SH  = 2 * LB_W;
   localparam int RECIP_W = MOD_SH - 3;
   localparam int PROD_W  = MOD_SH + LB_W;
   localparam logic [AW-1:0]      LAST_IDX  = AW'(LOGICAL_BLOCKS - 1);
   localparam logic [MOD_W-1:0]   MOD_DIV   = MOD_W'(LOGICAL_BLOCKS);
   localparam logic [RECIP_W-1:0] MOD_RECIP = RECIP_W'((64'd1 << MOD_SH) / LOGICAL_BLOCKS);
   localparam logic [CNT_W-1:0]   RUN_LIMIT = CNT_W'(MAX_RUN);
   localparam logic [ZID_W-1:0]   TOP_ZONE  = ZID_W'(NUM_ZONES - 1);

   // steps of the start index reduction
   localparam logic [1:0] MOD_QUOT = 2'd0;
   localparam logic [1:0] MOD_REM  = 2'd1;
   localparam logic [1:0] MOD_LAST = 2'd2;

   // configuration and allocation state
   logic [ZB_W-1:0]   zone_blocks_ff, zone_blocks_in;
   logic [ZID_W-1:0]  free_cnt_ff, free_cnt_in;
   logic [ZID_W-1:0]  zone_id_ff, zone_id_in;
   logic              zone_valid_ff, zone_valid_in;
   logic [WP_W-1:0]   wp_ff, wp_in;

   // per transaction registers
   logic              func_ff, func_in;
   logic [LB_W-1:0]   lb_ff, lb_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic [LB_W-1:0]   quot_ff, quot_in;
   logic [MOD_W-1:0]  mod_rem_ff, mod_rem_in;
   logic [1:0]        mod_cnt_ff, mod_cnt_in;
   logic [PHYS_W-1:0] prod_ff, prod_in;
   logic [PHYS_W-1:0] base_ff, base_in;
   logic [PHYS_W-1:0] phys_ff, phys_in;

   // result registers
   logic              rsp_strobe_ff, rsp_strobe_in;
   logic              rsp_last_ff, rsp_last_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic              rsp_sel_mem_ff, rsp_sel_mem_in;
   logic [PHYS_W-1:0] rsp_phys_ff, rsp_phys_in;

   // map table
   logic [PHYS_W-1:0] map_mem [LOGICAL_BLOCKS];
   logic [PHYS_W-1:0] map_rdata_ff;
   logic              map_we;
   logic [PHYS_W-1:0] map_wdata;

   logic [ZB_W-1:0]   zb_eff;
   logic [AW-1:0]     idx_next;
   logic [PROD_W-1:0] recip_prod;
   logic [MOD_W-1:0]  mod_next;
   logic [MUL_W-1:0]  mul_full;
   logic [ZB_W:0]     wp_end;

   // zone size clamped to its usable range
   always_comb begin
      if (zone_blocks_ff == '0) begin
         zb_eff = ZB_W'(1);
      end else if (zone_blocks_ff > ZB_MAX) begin
         zb_eff = ZB_MAX;
      end else begin
         zb_eff = zone_blocks_ff;
      end
   end

   // logical index walk with wrap at the table size
   assign idx_next = (idx_ff == LAST_IDX) ? '0 : idx_ff + AW'(1);

   // reciprocal quotient may be one short, so one compare and subtract finishes it
   assign recip_prod = PROD_W'(lb_ff) * PROD_W'(MOD_RECIP);
   assign mod_next   = (mod_rem_ff >= MOD_DIV) ? mod_rem_ff - MOD_DIV : mod_rem_ff;

   assign mul_full = zone_id_ff * zb_eff;
   assign wp_end   = {1'b0, wp_ff} + (ZB_W + 1)'(n_ff);

   // status towards the controller
   always_comb begin
      stat.clear_done = (idx_ff == LAST_IDX);
      stat.mod_done   = !NEED_MOD || (mod_cnt_ff == MOD_LAST);
      stat.empty_req  = (n_ff == '0);
      stat.too_long   = (n_ff > RUN_LIMIT) || (func_ff && (ZB_W'(n_ff) > zb_eff));
      stat.is_write   = func_ff;
      stat.fits       = zone_valid_ff && (wp_end <= {1'b0, zb_eff});
      stat.pool_empty = (free_cnt_ff == '0);
      stat.run_done   = ((cnt_ff + CNT_W'(1)) == n_ff);
   end

   // next state of the datapath registers
   always_comb begin
      zone_blocks_in = zone_blocks_ff;
      free_cnt_in    = free_cnt_ff;
      zone_id_in     = zone_id_ff;
      zone_valid_in  = zone_valid_ff;
      wp_in          = wp_ff;
      func_in        = func_ff;
      lb_in          = lb_ff;
      n_in           = n_ff;
      cnt_in         = cnt_ff;
      idx_in         = idx_ff;
      quot_in        = quot_ff;
      mod_rem_in     = mod_rem_ff;
      mod_cnt_in     = mod_cnt_ff;
      prod_in        = prod_ff;
      base_in        = base_ff;
      phys_in        = phys_ff;

      if (csr_valid && csr_ready) begin
         zone_blocks_in = csr_data;
      end

      // capture of a new transaction
      if (cmd.accept) begin
         func_in    = req_func;
         lb_in      = req_logical_block;
         n_in       = req_block_count;
         cnt_in     = '0;
         idx_in     = AW'(req_logical_block);
         mod_rem_in = '0;
         mod_cnt_in = '0;
      end

      // start index reduction for tables smaller than the logical block range
      if (cmd.mod_step && NEED_MOD) begin
         mod_cnt_in = mod_cnt_ff + 2'd1;
         if (mod_cnt_ff == MOD_QUOT) begin
            quot_in = recip_prod[MOD_SH +: LB_W];
         end else if (mod_cnt_ff == MOD_REM) begin
            mod_rem_in = {1'b0, lb_ff} - MOD_W'(quot_ff) * MOD_DIV;
         end else begin
            idx_in = AW'(mod_next);
         end
      end

      // a write that does not fit closes the open zone
      if (cmd.close_zone) begin
         zone_valid_in = 1'b0;
      end

      // free stack is only ever popped, so each entry still holds its own index
      if (cmd.pop) begin
         free_cnt_in   = free_cnt_ff - ZID_W'(1);
         zone_id_in    = free_cnt_ff - ZID_W'(1);
         zone_valid_in = 1'b1;
         wp_in         = '0;
      end

      if (cmd.mul) begin
         prod_in = PHYS_W'(mul_full);
      end

      if (cmd.add) begin
         base_in = prod_ff + PHYS_W'(wp_ff);
         phys_in = prod_ff + PHYS_W'(wp_ff);
      end

      if (cmd.clear_wr) begin
         idx_in = idx_next;
      end

      if (cmd.map_wr || cmd.map_rd) begin
         idx_in = idx_next;
         cnt_in = cnt_ff + CNT_W'(1);
      end

      if (cmd.map_wr) begin
         phys_in = phys_ff + PHYS_W'(1);
      end

      if (cmd.wp_advance) begin
         wp_in = wp_end[WP_W-1:0];
      end
   end

   // result register inputs
   always_comb begin
      rsp_strobe_in  = cmd.emit || cmd.map_rd;
      rsp_sel_mem_in = cmd.map_rd;
      rsp_last_in    = cmd.emit ? 1'b1 : stat.run_done;
      rsp_status_in  = cmd.emit ? cmd.emit_status : RS_OK;
      rsp_phys_in    = cmd.emit_base ? base_ff : '0;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         zone_blocks_ff <= ZB_MAX;
         free_cnt_ff    <= TOP_ZONE;
         zone_id_ff     <= TOP_ZONE;
         zone_valid_ff  <= 1'b1;
         wp_ff          <= '0;
         idx_ff         <= '0;
         cnt_ff         <= '0;
         mod_cnt_ff     <= '0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         zone_blocks_ff <= zone_blocks_in;
         free_cnt_ff    <= free_cnt_in;
         zone_id_ff     <= zone_id_in;
         zone_valid_ff  <= zone_valid_in;
         wp_ff          <= wp_in;
         idx_ff         <= idx_in;
         cnt_ff         <= cnt_in;
         mod_cnt_ff     <= mod_cnt_in;
         rsp_strobe_ff  <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      func_ff        <= func_in;
      lb_ff          <= lb_in;
      n_ff           <= n_in;
      quot_ff        <= quot_in;
      mod_rem_ff     <= mod_rem_in;
      prod_ff        <= prod_in;
      base_ff        <= base_in;
      phys_ff        <= phys_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_sel_mem_ff <= rsp_sel_mem_in;
      rsp_phys_ff    <= rsp_phys_in;
   end

   // map table: clearing pass writes zeros, write runs store consecutive blocks
   assign map_we    = cmd.clear_wr || cmd.map_wr;
   assign map_wdata = cmd.clear_wr ? '0 : phys_ff;

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[idx_ff] <= map_wdata;
      end
      if (cmd.map_rd) begin
         map_rdata_ff <= map_mem[idx_ff];
      end
   end

   assign csr_ready          = 1'b1;
   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_last           = rsp_last_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_physical_block = rsp_sel_mem_ff ? map_rdata_ff : rsp_phys_ff;

endmodule

`default_nettype wire
